// ===== rtl/core/sj_pkg.sv =====
// ---------------------------------------------------------------------------
// sj_pkg: shared types and tables for the Skipjack cipher pipeline
// Holds the F substitution table, the key byte selection and the word
// that travels from one round cell to the next.
// ---------------------------------------------------------------------------
package sj_pkg;

   localparam int BlockWidth  = 64;
   localparam int KeyLoWidth  = 64;
   localparam int KeyHiWidth  = 16;
   localparam int NumRounds   = 32;

   // Command codes
   localparam logic CMD_ENCRYPT = 1'b0;
   localparam logic CMD_DECRYPT = 1'b1;

   // Register indexes
   localparam logic CSR_KEY_LOW  = 1'b0;
   localparam logic CSR_KEY_HIGH = 1'b1;

   // Word handed from cell to cell
   typedef struct packed {
      logic                  valid;
      logic                  cmd;
      logic                  last;
      logic [BlockWidth-1:0] data;
   } sj_stage_type;

   localparam logic [7:0] FTAB [256] = '{
      8'ha3,8'hd7,8'h09,8'h83,8'hf8,8'h48,8'hf6,8'hf4,8'hb3,8'h21,8'h15,8'h78,8'h99,8'hb1,8'haf,8'hf9,
      8'he7,8'h2d,8'h4d,8'h8a,8'hce,8'h4c,8'hca,8'h2e,8'h52,8'h95,8'hd9,8'h1e,8'h4e,8'h38,8'h44,8'h28,
      8'h0a,8'hdf,8'h02,8'ha0,8'h17,8'hf1,8'h60,8'h68,8'h12,8'hb7,8'h7a,8'hc3,8'he9,8'hfa,8'h3d,8'h53,
      8'h96,8'h84,8'h6b,8'hba,8'hf2,8'h63,8'h9a,8'h19,8'h7c,8'hae,8'he5,8'hf5,8'hf7,8'h16,8'h6a,8'ha2,
      8'h39,8'hb6,8'h7b,8'h0f,8'hc1,8'h93,8'h81,8'h1b,8'hee,8'hb4,8'h1a,8'hea,8'hd0,8'h91,8'h2f,8'hb8,
      8'h55,8'hb9,8'hda,8'h85,8'h3f,8'h41,8'hbf,8'he0,8'h5a,8'h58,8'h80,8'h5f,8'h66,8'h0b,8'hd8,8'h90,
      8'h35,8'hd5,8'hc0,8'ha7,8'h33,8'h06,8'h65,8'h69,8'h45,8'h00,8'h94,8'h56,8'h6d,8'h98,8'h9b,8'h76,
      8'h97,8'hfc,8'hb2,8'hc2,8'hb0,8'hfe,8'hdb,8'h20,8'he1,8'heb,8'hd6,8'he4,8'hdd,8'h47,8'h4a,8'h1d,
      8'h42,8'hed,8'h9e,8'h6e,8'h49,8'h3c,8'hcd,8'h43,8'h27,8'hd2,8'h07,8'hd4,8'hde,8'hc7,8'h67,8'h18,
      8'h89,8'hcb,8'h30,8'h1f,8'h8d,8'hc6,8'h8f,8'haa,8'hc8,8'h74,8'hdc,8'hc9,8'h5d,8'h5c,8'h31,8'ha4,
      8'h70,8'h88,8'h61,8'h2c,8'h9f,8'h0d,8'h2b,8'h87,8'h50,8'h82,8'h54,8'h64,8'h26,8'h7d,8'h03,8'h40,
      8'h34,8'h4b,8'h1c,8'h73,8'hd1,8'hc4,8'hfd,8'h3b,8'hcc,8'hfb,8'h7f,8'hab,8'he6,8'h3e,8'h5b,8'ha5,
      8'had,8'h04,8'h23,8'h9c,8'h14,8'h51,8'h22,8'hf0,8'h29,8'h79,8'h71,8'h7e,8'hff,8'h8c,8'h0e,8'he2,
      8'h0c,8'hef,8'hbc,8'h72,8'h75,8'h6f,8'h37,8'ha1,8'hec,8'hd3,8'h8e,8'h62,8'h8b,8'h86,8'h10,8'he8,
      8'h08,8'h77,8'h11,8'hbe,8'h92,8'h4f,8'h24,8'hc5,8'h32,8'h36,8'h9d,8'hcf,8'hf3,8'ha6,8'hbb,8'hac,
      8'h5e,8'h6c,8'ha9,8'h13,8'h57,8'h25,8'hb5,8'he3,8'hbd,8'ha8,8'h3a,8'h01,8'h05,8'h59,8'h2a,8'h46
   };

   // One keyed feistel step of G: x xor F(y xor key byte)
   function automatic logic [7:0] sj_step(input logic [7:0] x, input logic [7:0] y,
                                          input logic [7:0] kb);
      return x ^ FTAB[y ^ kb];
   endfunction

   // Key byte n (0..9): bytes 0 and 1 come from the high register
   function automatic logic [7:0] sj_key_byte(input logic [KeyLoWidth-1:0] key_lo,
                                              input logic [KeyHiWidth-1:0] key_hi,
                                              input int n);
      logic [7:0] kb;
      if (n < 2) begin
         kb = key_hi[8*(1-n) +: 8];
      end else begin
         kb = key_lo[8*(9-n) +: 8];
      end
      return kb;
   endfunction

endpackage

// ===== rtl/core/skipjack_block_cipher_top.sv =====
// ---------------------------------------------------------------------------
// skipjack_block_cipher_top: pipelined Skipjack encrypt/decrypt engine
// A row of 32 round cells, two register stages each, taking one block
// per clock while the output is not stalled.
// ---------------------------------------------------------------------------
// Each block enters a chain of 32 round cells and leaves the last cell;
// one block is taken each cycle unless the output stalls. A cell holds
// one round in two register stages, each running two chained F-table
// lookups, and that pair of lookups sets the clock period. Encrypt and
// decrypt blocks may be mixed freely, the command travels with the word.
// The whole chain stalls while a finished word waits at the output. The
// 80-bit key is read live by every cell, so write it only while the pipe
// is empty; it resets to all zeros.
module skipjack_block_cipher_top (
   input  logic                          clock,
   input  logic                          reset,
   // input words
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [sj_pkg::BlockWidth-1:0] req_tdata,   // block_in
   input  logic                          req_tuser,   // command
   input  logic                          req_tlast,   // last_block
   // result words
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [sj_pkg::BlockWidth-1:0] rsp_tdata,   // block_out
   output logic                          rsp_tlast,   // last_out
   // key registers
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [sj_pkg::KeyLoWidth-1:0] csr_data
);
   import sj_pkg::*;

   logic [KeyLoWidth-1:0] key_low_ff;
   logic [KeyHiWidth-1:0] key_high_ff;
   logic                  enable;
   sj_stage_type          chain [NumRounds+1];

   assign csr_ready = 1'b1;

   // Update the key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_KEY_LOW:  key_low_ff  <= csr_data;
            CSR_KEY_HIGH: key_high_ff <= csr_data[KeyHiWidth-1:0];
            default:      key_low_ff  <= key_low_ff;
         endcase
      end
   end

   // Advance the chain unless a result word is stalled
   assign enable     = !chain[NumRounds].valid || rsp_tready;
   assign req_tready = enable;

   assign chain[0].valid = req_tvalid;
   assign chain[0].cmd   = req_tuser;
   assign chain[0].last  = req_tlast;
   assign chain[0].data  = req_tdata;

   for (genvar i = 0; i < NumRounds; i++) begin : g_cell
      sj_round_cell #(
         .Round(i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (enable),
         .key_low  (key_low_ff),
         .key_high (key_high_ff),
         .stage_in (chain[i]),
         .stage_out(chain[i+1])
      );
   end

   assign rsp_tvalid = chain[NumRounds].valid;
   assign rsp_tdata  = chain[NumRounds].data;
   assign rsp_tlast  = chain[NumRounds].last;

endmodule

// ===== rtl/core/sj_round_cell.sv =====
// ---------------------------------------------------------------------------
// sj_round_cell: one Skipjack round, split over two register stages
// The first stage runs the first two steps of G (or its inverse), the
// second stage the last two steps and the rule A or rule B word update.
// Encryption runs round Round here, decryption round 31-Round.
// ---------------------------------------------------------------------------
module sj_round_cell #(
   parameter int Round = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  logic [sj_pkg::KeyLoWidth-1:0] key_low,
   input  logic [sj_pkg::KeyHiWidth-1:0] key_high,
   input  sj_pkg::sj_stage_type          stage_in,
   output sj_pkg::sj_stage_type          stage_out
);
   import sj_pkg::*;

   localparam logic [4:0] K_ENC = 5'(Round);
   localparam logic [4:0] K_DEC = 5'(NumRounds - 1 - Round);
   localparam int KE0 = (4 * Round) % 10;
   localparam int KE1 = (4 * Round + 1) % 10;
   localparam int KE2 = (4 * Round + 2) % 10;
   localparam int KE3 = (4 * Round + 3) % 10;
   localparam int KD0 = (4 * (NumRounds - 1 - Round)) % 10;
   localparam int KD1 = (4 * (NumRounds - 1 - Round) + 1) % 10;
   localparam int KD2 = (4 * (NumRounds - 1 - Round) + 2) % 10;
   localparam int KD3 = (4 * (NumRounds - 1 - Round) + 3) % 10;

   // first stage signals
   logic [15:0] g_word;
   logic [7:0]  x0, y0, s1, s2, ka, kb;
   // mid registers
   logic        mid_valid_ff, mid_valid_in;
   logic        mid_cmd_ff;
   logic        mid_last_ff;
   logic [63:0] mid_data_ff;
   logic [7:0]  mid_x_ff, mid_y_ff;
   // second stage signals
   logic [7:0]  s3, s4, kc, kd;
   logic [4:0]  k_num;
   logic [15:0] cnt, g_res;
   logic [15:0] w0, w1, w2, w3, n0, n1, n2, n3;
   // output registers
   logic        out_valid_ff;
   logic        out_cmd_ff;
   logic        out_last_ff;
   logic [63:0] out_data_ff, out_data_in;

   // Pick the G input; the inverse runs with halves swapped and keys reversed
   always_comb begin
      if (stage_in.cmd == CMD_DECRYPT) begin
         g_word = stage_in.data[47:32];
         x0     = g_word[7:0];
         y0     = g_word[15:8];
         ka     = sj_key_byte(key_low, key_high, KD3);
         kb     = sj_key_byte(key_low, key_high, KD2);
      end else begin
         g_word = stage_in.data[63:48];
         x0     = g_word[15:8];
         y0     = g_word[7:0];
         ka     = sj_key_byte(key_low, key_high, KE0);
         kb     = sj_key_byte(key_low, key_high, KE1);
      end
      s1 = sj_step(x0, y0, ka);
      s2 = sj_step(y0, s1, kb);
   end

   assign mid_valid_in = stage_in.valid;

   // Hold the half-finished G in the mid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
      end else if (enable) begin
         mid_valid_ff <= mid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         mid_cmd_ff  <= stage_in.cmd;
         mid_last_ff <= stage_in.last;
         mid_data_ff <= stage_in.data;
         mid_x_ff    <= s1;
         mid_y_ff    <= s2;
      end
   end

   // Finish G and apply the round rule
   always_comb begin
      if (mid_cmd_ff == CMD_DECRYPT) begin
         k_num = K_DEC;
         kc    = sj_key_byte(key_low, key_high, KD1);
         kd    = sj_key_byte(key_low, key_high, KD0);
      end else begin
         k_num = K_ENC;
         kc    = sj_key_byte(key_low, key_high, KE2);
         kd    = sj_key_byte(key_low, key_high, KE3);
      end
      s3  = sj_step(mid_x_ff, mid_y_ff, kc);
      s4  = sj_step(mid_y_ff, s3, kd);
      cnt = 16'(k_num) + 16'd1;
      w0  = mid_data_ff[63:48];
      w1  = mid_data_ff[47:32];
      w2  = mid_data_ff[31:16];
      w3  = mid_data_ff[15:0];
      if (mid_cmd_ff == CMD_DECRYPT) begin
         g_res = {s4, s3};
         n0    = g_res;
         if (k_num[3]) begin
            n1 = w2 ^ g_res ^ cnt;
            n2 = w3;
            n3 = w0;
         end else begin
            n1 = w2;
            n2 = w3;
            n3 = w0 ^ w1 ^ cnt;
         end
      end else begin
         g_res = {s3, s4};
         n1    = g_res;
         n3    = w2;
         if (k_num[3]) begin
            n0 = w3;
            n2 = w0 ^ w1 ^ cnt;
         end else begin
            n0 = g_res ^ w3 ^ cnt;
            n2 = w1;
         end
      end
      out_data_in = {n0, n1, n2, n3};
   end

   // Hand the round result to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         out_valid_ff <= mid_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         out_cmd_ff  <= mid_cmd_ff;
         out_last_ff <= mid_last_ff;
         out_data_ff <= out_data_in;
      end
   end

   assign stage_out.valid = out_valid_ff;
   assign stage_out.cmd   = out_cmd_ff;
   assign stage_out.last  = out_last_ff;
   assign stage_out.data  = out_data_ff;

endmodule
